// ===== rtl/dro_pkg.sv =====
// Shared types, widths and constants for the dead-reckoning odometry block.
package dro_pkg;

  localparam int CW      = 34;
  localparam int TRIG_W  = 21;
  localparam int PROD_W  = 45;
  localparam int DELTA_W = 30;
  localparam int ATAN_N  = 24;

  localparam logic signed [CW-1:0] CORDIC_GAIN  = 34'sh0_26DD_3B6A;
  localparam logic signed [CW-1:0] QUARTER_TURN = 34'sh0_4000_0000;
  localparam logic signed [CW-1:0] HALF_TURN    = 34'sh0_8000_0000;

  localparam logic [31:0] ATAN_TURN [ATAN_N] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 flip;
  } cordic_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BUSY,
    ST_COMMIT
  } state_t;

endpackage

// ===== rtl/dro_cordic_cell.sv =====
// One CORDIC rotation cell: a fixed shift and arctangent step, registered.
module dro_cordic_cell
  import dro_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_v,
  input  cordic_t in_d,
  output logic    out_v,
  output cordic_t out_d
);

  localparam logic signed [CW-1:0] ANGLE = CW'(ATAN_TURN[STEP]);

  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  cordic_t              d_next;

  always_comb begin
    xs = in_d.x >>> STEP;
    ys = in_d.y >>> STEP;
    d_next.flip = in_d.flip;
    if (!in_d.z[CW-1]) begin
      d_next.x = in_d.x - ys;
      d_next.y = in_d.y + xs;
      d_next.z = in_d.z - ANGLE;
    end else begin
      d_next.x = in_d.x + ys;
      d_next.y = in_d.y - xs;
      d_next.z = in_d.z + ANGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else begin
      out_v <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    out_d <= d_next;
  end

endmodule

// ===== rtl/dro_sincos.sv =====
// Cosine and sine of the heading: quadrant fold, a row of CORDIC cells, unfold.
module dro_sincos
  import dro_pkg::*;
#(
  parameter int ANGLE_BITS   = 24,
  parameter int SINCOS_STEPS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [ANGLE_BITS-1:0]    angle,
  output logic                     done,
  output logic signed [TRIG_W-1:0] cos_q18,
  output logic signed [TRIG_W-1:0] sin_q18
);

  localparam int SH = 32 - ANGLE_BITS;

  logic [31:0]          turn;
  logic signed [CW-1:0] z0;
  cordic_t              seed;
  logic                 sv [SINCOS_STEPS+1];
  cordic_t              sd [SINCOS_STEPS+1];
  logic signed [CW-1:0] c30;
  logic signed [CW-1:0] s30;

  always_comb begin
    turn      = 32'(angle) << SH;
    z0        = CW'($signed(turn));
    seed.x    = CORDIC_GAIN;
    seed.y    = '0;
    seed.flip = 1'b0;
    seed.z    = z0;
    if (z0 > QUARTER_TURN) begin
      seed.z    = z0 - HALF_TURN;
      seed.flip = 1'b1;
    end else if (z0 < -QUARTER_TURN) begin
      seed.z    = z0 + HALF_TURN;
      seed.flip = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sv[0] <= 1'b0;
    end else begin
      sv[0] <= start;
    end
  end

  always_ff @(posedge clk) begin
    sd[0] <= seed;
  end

  for (genvar i = 0; i < SINCOS_STEPS; i++) begin : g_cell
    dro_cordic_cell #(
      .STEP (i)
    ) u_cell (
      .clk   (clk),
      .rst   (rst),
      .in_v  (sv[i]),
      .in_d  (sd[i]),
      .out_v (sv[i+1]),
      .out_d (sd[i+1])
    );
  end

  assign c30 = sd[SINCOS_STEPS].flip ? -sd[SINCOS_STEPS].x : sd[SINCOS_STEPS].x;
  assign s30 = sd[SINCOS_STEPS].flip ? -sd[SINCOS_STEPS].y : sd[SINCOS_STEPS].y;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= sv[SINCOS_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    cos_q18 <= c30[TRIG_W+11:12];
    sin_q18 <= s30[TRIG_W+11:12];
  end

endmodule

// ===== rtl/dro_scale.sv =====
// One axis of displacement: speed times trig times elapsed time, floored to 2^-16 m.
module dro_scale
  import dro_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic signed [23:0]        speed,
  input  logic signed [TRIG_W-1:0]  trig,
  input  logic [19:0]               dt,
  output logic                      done,
  output logic signed [DELTA_W-1:0] delta
);

  logic                     v1;
  logic                     v2;
  logic                     v3;
  logic signed [PROD_W-1:0] st;
  logic [42:0]              lo_prod;
  logic signed [42:0]       hi_prod;
  logic signed [65:0]       hi_ext;
  logic signed [65:0]       lo_ext;
  logic signed [65:0]       sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= start;
      v2   <= v1;
      v3   <= v2;
      done <= v3;
    end
  end

  assign hi_ext = 66'(hi_prod);
  assign lo_ext = 66'(lo_prod);
  assign sum    = (hi_ext <<< 23) + lo_ext;

  always_ff @(posedge clk) begin
    st      <= speed * trig;
    lo_prod <= st[22:0] * dt;
    hi_prod <= $signed(st[PROD_W-1:23]) * $signed({1'b0, dt});
    delta   <= sum[DELTA_W+33:34];
  end

endmodule

// ===== rtl/dead_reckoning_odometry.sv =====
// Top level of the dead-reckoning odometry block: request control and pose state.
// An accepted request passes the quadrant fold, the row of CORDIC cells and the multiply
// path, and out_valid rises at commit once the output register is free; one request is
// in flight at a time, so a new request waits until the last one has committed.
// A finished result waits in the output register while the next request runs.
// Reset (rst, synchronous) clears the position and heading accumulators to zero.
module dead_reckoning_odometry
  import dro_pkg::*;
#(
  parameter int ANGLE_BITS   = 24,
  parameter int SINCOS_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [19:0]        elapsed_time,
  input  logic signed [23:0] forward_speed,
  input  logic signed [23:0] yaw_rate,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic [23:0]        heading,
  output logic signed [23:0] speed_echo,
  output logic signed [23:0] rate_echo
);

  localparam int HW = (ANGLE_BITS > 24) ? ANGLE_BITS : 24;

  state_t                    state;
  state_t                    state_next;
  logic                      accept;
  logic                      commit;
  logic                      go;
  logic [19:0]               dt;
  logic signed [23:0]        speed;
  logic signed [23:0]        rate;
  logic signed [PROD_W-1:0]  rd;
  logic signed [31:0]        x_accum;
  logic signed [31:0]        y_accum;
  logic [ANGLE_BITS-1:0]     yaw_accum;
  logic [ANGLE_BITS-1:0]     yaw_next;
  logic signed [32:0]        x_sum;
  logic signed [32:0]        y_sum;
  logic signed [31:0]        x_next;
  logic signed [31:0]        y_next;
  logic [HW-1:0]             yaw_wide;
  logic                      trig_v;
  logic signed [TRIG_W-1:0]  cos_q18;
  logic signed [TRIG_W-1:0]  sin_q18;
  logic                      done_x;
  logic                      done_y;
  logic                      done;
  logic signed [DELTA_W-1:0] dx;
  logic signed [DELTA_W-1:0] dy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    commit     = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = ST_BUSY;
        end
      end
      ST_BUSY: begin
        if (done) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (!out_valid || !out_stall) begin
          commit     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign accept = in_valid && !in_stall;
  assign done   = done_x && done_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      go <= 1'b0;
    end else begin
      go <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dt    <= elapsed_time;
      speed <= forward_speed;
      rate  <= yaw_rate;
    end
    rd <= rate * $signed({1'b0, dt});
  end

  dro_sincos #(
    .ANGLE_BITS   (ANGLE_BITS),
    .SINCOS_STEPS (SINCOS_STEPS)
  ) u_sincos (
    .clk     (clk),
    .rst     (rst),
    .start   (go),
    .angle   (yaw_accum),
    .done    (trig_v),
    .cos_q18 (cos_q18),
    .sin_q18 (sin_q18)
  );

  dro_scale u_scale_x (
    .clk   (clk),
    .rst   (rst),
    .start (trig_v),
    .speed (speed),
    .trig  (cos_q18),
    .dt    (dt),
    .done  (done_x),
    .delta (dx)
  );

  dro_scale u_scale_y (
    .clk   (clk),
    .rst   (rst),
    .start (trig_v),
    .speed (speed),
    .trig  (sin_q18),
    .dt    (dt),
    .done  (done_y),
    .delta (dy)
  );

  always_comb begin
    x_sum    = 33'(x_accum) + 33'(dx);
    y_sum    = 33'(y_accum) + 33'(dy);
    x_next   = x_sum[31:0];
    y_next   = y_sum[31:0];
    if (x_sum[32] != x_sum[31]) begin
      x_next = x_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    if (y_sum[32] != y_sum[31]) begin
      y_next = y_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    yaw_next = yaw_accum + rd[31 -: ANGLE_BITS];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_accum   <= '0;
      y_accum   <= '0;
      yaw_accum <= '0;
      out_valid <= 1'b0;
    end else begin
      if (commit) begin
        x_accum   <= x_next;
        y_accum   <= y_next;
        yaw_accum <= yaw_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign yaw_wide = HW'(yaw_next);

  always_ff @(posedge clk) begin
    if (commit) begin
      pos_x      <= x_next;
      pos_y      <= y_next;
      heading    <= yaw_wide[23:0];
      speed_echo <= speed;
      rate_echo  <= rate;
    end
  end

  a_trig_busy : assert property (@(posedge clk) disable iff (rst)
    trig_v |-> state == ST_BUSY)
    else $error("sine and cosine finished outside a busy request");

  a_done_busy : assert property (@(posedge clk) disable iff (rst)
    done |-> state == ST_BUSY)
    else $error("displacement finished outside a busy request");

  a_scale_pair : assert property (@(posedge clk) disable iff (rst)
    done_x == done_y)
    else $error("axis multiply paths out of step");

  a_idle_empty : assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !go && !trig_v && !done)
    else $error("request taken while another is in flight");

  a_out_rise : assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_COMMIT)
    else $error("result raised without a commit");

endmodule

// ===== bench/dro_pose_checker.sv =====
// Pose checker for the dead-reckoning odometry block: predicts each pose and compares results.
module dro_pose_checker #(
  parameter int ANGLE_BITS   = 24,
  parameter int SINCOS_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [19:0]        elapsed_time,
  input  logic signed [23:0] forward_speed,
  input  logic signed [23:0] yaw_rate,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic [23:0]        heading,
  input  logic signed [23:0] speed_echo,
  input  logic signed [23:0] rate_echo,
  output int                 errors,
  output int                 outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint GAIN_Q30 = 64'h26DD_3B6A;
  localparam longint QUARTER  = 64'h4000_0000;
  localparam longint HALF     = 64'h8000_0000;
  localparam longint ATAN_LUT [24] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
    64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
    64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
    64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
    64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
  };

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [23:0]        hdg;
    logic signed [23:0] speed;
    logic signed [23:0] rate;
  } pose_t;

  logic signed [31:0] x_pos = '0;
  logic signed [31:0] y_pos = '0;
  logic [63:0]        yaw_angle = '0;
  pose_t              expected_poses [$];
  int                 fail_count = 0;
  int                 pending_count = 0;

  assign errors      = fail_count;
  assign outstanding = pending_count;

  function automatic void heading_trig(input logic [63:0] ang, output longint c30,
                                       output longint s30);
    longint z, cx, cy, xs, ys;
    bit     flip;
    z    = longint'((ang << (32 - ANGLE_BITS)) & 64'hFFFF_FFFF);
    cx   = GAIN_Q30;
    cy   = 0;
    flip = 1'b0;
    if (z >= HALF) z -= 2 * HALF;
    if (z > QUARTER) begin
      z -= HALF;
      flip = 1'b1;
    end else if (z < -QUARTER) begin
      z += HALF;
      flip = 1'b1;
    end
    for (int i = 0; i < SINCOS_STEPS && i < 24; i++) begin
      xs = cx >>> i;
      ys = cy >>> i;
      if (z >= 0) begin
        cx -= ys;
        cy += xs;
        z  -= ATAN_LUT[i];
      end else begin
        cx += ys;
        cy -= xs;
        z  += ATAN_LUT[i];
      end
    end
    c30 = flip ? -cx : cx;
    s30 = flip ? -cy : cy;
  endfunction

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic pose_t advance_pose(input logic [19:0] dt, input logic signed [23:0] sp,
                                         input logic signed [23:0] rt);
    longint      c30, s30, travel, turn;
    logic [63:0] turn_bits;
    pose_t       p;
    heading_trig(yaw_angle, c30, s30);
    travel    = longint'(dt) * longint'(sp);
    x_pos     = clamp32(longint'(x_pos) + ((travel * (c30 >>> 12)) >>> 34));
    y_pos     = clamp32(longint'(y_pos) + ((travel * (s30 >>> 12)) >>> 34));
    turn      = longint'(rt) * longint'(dt);
    turn_bits = turn;
    yaw_angle = (yaw_angle + (turn_bits >> (32 - ANGLE_BITS)))
              & ((64'd1 << ANGLE_BITS) - 64'd1);
    p.x     = x_pos;
    p.y     = y_pos;
    p.hdg   = yaw_angle[23:0];
    p.speed = sp;
    p.rate  = rt;
    return p;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t dro_pose_checker: %s got %h expected %h", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    pose_t want;
    if (rst) begin
      x_pos     = '0;
      y_pos     = '0;
      yaw_angle = '0;
      expected_poses.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_poses.size() == 0) begin
          report_mismatch("result with no request, pos_x", pos_x, '0);
        end else begin
          want = expected_poses.pop_front();
          if (pos_x !== want.x) report_mismatch("pos_x", pos_x, want.x);
          if (pos_y !== want.y) report_mismatch("pos_y", pos_y, want.y);
          if (heading !== want.hdg)
            report_mismatch("heading", 32'(heading), 32'(want.hdg));
          if (speed_echo !== want.speed)
            report_mismatch("speed_echo", 32'(speed_echo), 32'(want.speed));
          if (rate_echo !== want.rate)
            report_mismatch("rate_echo", 32'(rate_echo), 32'(want.rate));
        end
      end
      if (in_valid && !in_stall)
        expected_poses.push_back(advance_pose(elapsed_time, forward_speed, yaw_rate));
    end
    pending_count <= expected_poses.size();
  end

endmodule

// ===== bench/tb_dead_reckoning_odometry.sv =====
// Testbench top for the dead-reckoning odometry block: reset, request stimulus and verdict.
module tb_dead_reckoning_odometry;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ANGLE_BITS      = 24;
  localparam int SINCOS_STEPS    = 16;
  localparam int LATENCY         = SINCOS_STEPS + 9;
  localparam int RANDOM_REQUESTS = 630;

  typedef enum int {
    RUN_ANY,
    RUN_DRIVE,
    RUN_SPIN,
    RUN_CREEP,
    RUN_QUARTER
  } run_kind_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [19:0]        elapsed_time = '0;
  logic signed [23:0] forward_speed = '0;
  logic signed [23:0] yaw_rate = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic [23:0]        heading;
  logic signed [23:0] speed_echo;
  logic signed [23:0] rate_echo;
  int                 errors;
  int                 outstanding;
  bit                 gaps_on = 1'b1;

  dead_reckoning_odometry #(
    .ANGLE_BITS  (ANGLE_BITS),
    .SINCOS_STEPS(SINCOS_STEPS)
  ) dut (.*);

  dro_pose_checker #(
    .ANGLE_BITS  (ANGLE_BITS),
    .SINCOS_STEPS(SINCOS_STEPS)
  ) pose_check (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("tb_dead_reckoning_odometry: FAIL");
    $finish;
  end

  always @(posedge clk) begin
    out_stall <= gaps_on && ($urandom_range(99) < 37);
  end

  task automatic push_request(input logic [19:0] dt, input logic signed [23:0] sp,
                              input logic signed [23:0] rt);
    while (gaps_on && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    elapsed_time  <= dt;
    forward_speed <= sp;
    yaw_rate      <= rt;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain_poses();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic random_request(input run_kind_t kind, input bit neg);
    logic [19:0]        dt;
    logic signed [23:0] sp;
    logic signed [23:0] rt;
    logic [8:0]         nudge;
    case (kind)
      RUN_DRIVE: begin
        dt = 20'($urandom_range(20'hFFFFF, 20'hC0000));
        sp = 24'($urandom_range(24'h7FFFFF, 24'h600000));
        if (neg) sp = -sp;
        rt = '0;
      end
      RUN_SPIN: begin
        dt = 20'($urandom_range(20'hFFFFF, 1));
        sp = 24'($urandom);
        rt = 24'($urandom_range(24'h7FFFFF, 24'h100000));
        if (neg) rt = -rt;
      end
      RUN_CREEP: begin
        dt    = 20'($urandom_range(255));
        nudge = 9'($urandom);
        sp    = {{15{nudge[8]}}, nudge};
        nudge = 9'($urandom);
        rt    = {{15{nudge[8]}}, nudge};
      end
      RUN_QUARTER: begin
        dt = 20'h10000;
        sp = 24'($urandom);
        rt = ($urandom_range(1) != 0) ? 24'sd16384 : 24'sd8192;
        if (neg) rt = -rt;
      end
      default: begin
        dt = 20'($urandom);
        sp = 24'($urandom);
        rt = 24'($urandom);
      end
    endcase
    push_request(dt, sp, rt);
  endtask

  initial begin
    run_kind_t kind;
    bit        neg;
    int        sent;
    int        burst;
    int        next_pause;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    push_request(20'd0, 24'sh7FFFFF, 24'sh7FFFFF);
    repeat (5) push_request(20'h10000, 24'sh7FFFFF, 24'sd16384);
    repeat (4) push_request(20'h10000, 24'sh800000, -24'sd16384);
    repeat (2) push_request(20'h10000, 24'sh400000, 24'sd8192);
    push_request(20'hFFFFF, 24'sh7FFFFF, 24'sd0);
    push_request(20'hFFFFF, 24'sh800000, 24'sd0);
    push_request(20'd1, 24'sd1, 24'sd1);
    push_request(20'hFFFFF, -24'sd1, -24'sd1);
    push_request(20'hFFFFF, 24'sd0, 24'sh7FFFFF);
    push_request(20'hFFFFF, 24'sd0, 24'sh800000);
    push_request(20'd0, 24'sh800000, 24'sh800000);
    drain_poses();

    sent       = 0;
    next_pause = 150;
    while (sent < RANDOM_REQUESTS) begin
      kind    = run_kind_t'($urandom_range(RUN_QUARTER));
      neg     = 1'($urandom_range(1));
      burst   = (kind == RUN_DRIVE) ? $urandom_range(40, 25) : $urandom_range(30, 5);
      gaps_on = !(sent >= 250 && sent < 360);
      repeat (burst) begin
        random_request(kind, neg);
        sent++;
      end
      if (sent >= next_pause) begin
        drain_poses();
        next_pause += 150;
      end
    end
    gaps_on = 1'b1;

    drain_poses();
    repeat (2 * LATENCY) @(posedge clk);
    if (errors == 0)
      $display("tb_dead_reckoning_odometry: PASS");
    else
      $display("tb_dead_reckoning_odometry: FAIL");
    $finish;
  end

endmodule
